// File: rtl/bpsc_pkg.sv
package bpsc_pkg;

  localparam int GRID_MAX = 64;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int SIZE_W   = 7;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 5;
  localparam int PROD_W   = POS_W + SIZE_W;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(10);
  localparam logic [SIZE_W-1:0] GRID_SIZE_MAX   = SIZE_W'(GRID_MAX);

  typedef enum logic [1:0] {
    OP_WR_WORK   = 2'd0,
    OP_WR_SAMPLE = 2'd1,
    OP_FULL      = 2'd2,
    OP_CROSS     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ARM_FULL  = 2'd0,
    ARM_VERT  = 2'd1,
    ARM_HORIZ = 2'd2
  } arm_t;

  typedef logic signed [3:0] off_t;
  typedef logic signed [7:0] coord_t;

  typedef struct packed {
    logic active;
    logic last;
    arm_t arm;
    off_t dr;
    off_t dc;
  } seq_step_t;

  function automatic logic in_range(coord_t v, logic [SIZE_W-1:0] s);
    return !v[7] && (v[6:0] < s);
  endfunction

  function automatic coord_t offset(logic [POS_W-1:0] p, off_t d);
    return $signed({2'b00, p}) + $signed({{4{d[3]}}, d});
  endfunction

  function automatic logic [ADDR_W-1:0] lin_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                                 logic [SIZE_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(r) * PROD_W'(s);
    return ADDR_W'(p + PROD_W'(c));
  endfunction

endpackage

// File: rtl/bpsc_req_if.sv
interface bpsc_req_if import bpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  sample_row;
  logic [POS_W-1:0]  sample_col;
  logic              pixel_type;

  modport source (output valid, opcode, row, col, sample_row, sample_col, pixel_type,
                  input ready);
  modport sink (input valid, opcode, row, col, sample_row, sample_col, pixel_type,
                output ready);
endinterface

// File: rtl/bpsc_rsp_if.sv
interface bpsc_rsp_if import bpsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] similar_count;

  modport source (output valid, similar_count, input ready);
  modport sink (input valid, similar_count, output ready);
endinterface

// File: rtl/bpsc_cfg_if.sv
interface bpsc_cfg_if import bpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink (input valid, grid_size, output ready);
endinterface

// File: rtl/bpsc_ram.sv
module bpsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/bpsc_seq.sv
module bpsc_seq import bpsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cross_mode,
  output seq_step_t step
);

  logic       running;
  logic [2:0] i;
  logic [2:0] j;
  arm_t       arm;

  always_comb begin
    step.active = running;
    step.arm    = arm;
    step.dr     = (arm == ARM_HORIZ) ? off_t'(0) : $signed({1'b0, i}) - 4'sd2;
    step.dc     = (arm == ARM_VERT) ? off_t'(0) : $signed({1'b0, j}) - 4'sd2;
    case (arm)
      ARM_FULL:  step.last = (i == 3'd4) && (j == 3'd4);
      ARM_VERT:  step.last = 1'b0;
      ARM_HORIZ: step.last = (j == 3'd4);
      default:   step.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      i       <= 3'd0;
      j       <= 3'd0;
      arm     <= cross_mode ? ARM_VERT : ARM_FULL;
    end else if (running) begin
      case (arm)
        ARM_FULL: begin
          if (j == 3'd4) begin
            j <= 3'd0;
            i <= i + 3'd1;
          end else begin
            j <= j + 3'd1;
          end
        end
        ARM_VERT: begin
          if (i == 3'd4) begin
            arm <= ARM_HORIZ;
            j   <= 3'd0;
          end else begin
            i <= i + 3'd1;
          end
        end
        ARM_HORIZ: begin
          // horizontal arm skips its center
          j <= (j == 3'd1) ? 3'd3 : j + 3'd1;
        end
        default: begin
          arm <= ARM_FULL;
        end
      endcase
      if (step.last) begin
        running <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/binary_patch_similarity_counter_top.sv
// Pixel write: ready stays high on the next cycle.
// Full 5x5 query: 25 pixel-pair reads, then the result is loaded.
// Cross query: 9 pixel-pair reads, then the result is loaded.
// One read per cycle from each image RAM; next request taken in the cycle after the result loads.
// Reset (rst, synchronous): grid_size to 10, control idle; image RAMs are not cleared.
module binary_patch_similarity_counter_top import bpsc_pkg::*; (
  input logic         clk,
  input logic         rst,
  bpsc_req_if.sink    req,
  bpsc_rsp_if.source  rsp,
  bpsc_cfg_if.sink    cfg
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [SIZE_W-1:0]  grid_size;
  logic [SIZE_W-1:0]  size;

  logic [POS_W-1:0]   q_row;
  logic [POS_W-1:0]   q_col;
  logic [POS_W-1:0]   q_srow;
  logic [POS_W-1:0]   q_scol;

  logic               req_xfer;
  logic               query_start;
  seq_step_t          step;

  coord_t             wr;
  coord_t             wc;
  coord_t             sr;
  coord_t             sc;
  logic               wr_ok;
  logic               wc_ok;
  logic               sr_ok;
  logic               sc_ok;
  logic               gate;

  logic               work_we;
  logic               samp_we;
  logic [ADDR_W-1:0]  work_addr;
  logic [ADDR_W-1:0]  samp_addr;
  logic               work_px;
  logic               samp_px;

  logic               p1_valid;
  logic               p1_gate;
  logic               p1_win;
  logic               p1_sin;
  logic               pair_eq;
  logic [COUNT_W-1:0] count;
  logic               load_out;

  assign size        = (grid_size > GRID_SIZE_MAX) ? GRID_SIZE_MAX : grid_size;
  assign cfg.ready   = 1'b1;
  assign req.ready   = (state == S_IDLE);
  assign req_xfer    = req.valid && req.ready;
  assign query_start = req_xfer && ((req.opcode == OP_FULL) || (req.opcode == OP_CROSS));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      grid_size <= cfg.grid_size;
    end
  end

  bpsc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (query_start),
    .cross_mode (req.opcode == OP_CROSS),
    .step       (step)
  );

  always_ff @(posedge clk) begin
    if (query_start) begin
      q_row  <= req.row;
      q_col  <= req.col;
      q_srow <= req.sample_row;
      q_scol <= req.sample_col;
    end
  end

  always_comb begin
    wr    = offset(q_row, step.dr);
    wc    = offset(q_col, step.dc);
    sr    = offset(q_srow, step.dr);
    sc    = offset(q_scol, step.dc);
    wr_ok = in_range(wr, size);
    wc_ok = in_range(wc, size);
    sr_ok = in_range(sr, size);
    sc_ok = in_range(sc, size);
    case (step.arm)
      ARM_FULL:  gate = wr_ok && wc_ok && sr_ok && sc_ok;
      ARM_VERT:  gate = wr_ok && sr_ok;
      ARM_HORIZ: gate = wc_ok && sc_ok;
      default:   gate = 1'b0;
    endcase
  end

  always_comb begin
    work_we = req_xfer && (req.opcode == OP_WR_WORK) &&
              (POS_W'(req.row) < size) && (POS_W'(req.col) < size);
    samp_we = req_xfer && (req.opcode == OP_WR_SAMPLE) &&
              (POS_W'(req.sample_row) < size) && (POS_W'(req.sample_col) < size);
    if (state == S_IDLE) begin
      work_addr = lin_addr(req.row, req.col, size);
      samp_addr = lin_addr(req.sample_row, req.sample_col, size);
    end else begin
      work_addr = lin_addr(wr[POS_W-1:0], wc[POS_W-1:0], size);
      samp_addr = lin_addr(sr[POS_W-1:0], sc[POS_W-1:0], size);
    end
  end

  bpsc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .addr  (work_addr),
    .wdata (req.pixel_type),
    .rdata (work_px)
  );

  bpsc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .addr  (samp_addr),
    .wdata (req.pixel_type),
    .rdata (samp_px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= step.active;
    end
    p1_gate <= gate;
    p1_win  <= wr_ok && wc_ok;
    p1_sin  <= sr_ok && sc_ok;
  end

  // two off-grid reads compare equal
  assign pair_eq = p1_gate && ((p1_win && p1_sin && (work_px == samp_px)) ||
                               (!p1_win && !p1_sin));

  always_ff @(posedge clk) begin
    if (query_start) begin
      count <= '0;
    end else if (p1_valid) begin
      count <= count + COUNT_W'(pair_eq);
    end
  end

  assign load_out = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (query_start) state_next = S_SCAN;
      S_SCAN:  if (step.active && step.last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.similar_count <= count;
    end
  end

endmodule

// File: rtl/bpsc_checker.sv
module bpsc_checker import bpsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [1:0]         req_opcode,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [COUNT_W-1:0] rsp_similar_count
);

  logic req_xfer;
  assign req_xfer = req_valid && req_ready;

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_xfer && ((req_opcode == OP_FULL) || (req_opcode == OP_CROSS)) |=> !req_ready)
    else $error("query transfer did not drop ready");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    req_xfer && ((req_opcode == OP_WR_WORK) || (req_opcode == OP_WR_SAMPLE)) |=> req_ready)
    else $error("pixel write took more than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_similar_count <= COUNT_W'(25)))
    else $error("similar_count above 25");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_similar_count))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind binary_patch_similarity_counter_top bpsc_checker u_bpsc_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_opcode        (req.opcode),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_similar_count (rsp.similar_count)
);
